@@ sv/dvrt_pkg.sv @@
// Shared types and constants for the distance-vector route table.
package dvrt_pkg;

    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_NONE   = 2'd1;
    localparam logic [1:0] KIND_VIA    = 2'd2;

    localparam logic [4:0] METRIC_INF  = 5'd16;
    localparam logic [4:0] METRIC_ONE  = 5'd1;

    typedef enum logic [1:0] {
        CMD_ADVERT      = 2'd0,
        CMD_REACHABLE   = 2'd1,
        CMD_UNREACHABLE = 2'd2,
        CMD_DUMP        = 2'd3
    } dvrt_cmd_t;

    // Token that walks the cell chain, one cell per cycle while the chain advances.
    typedef struct packed {
        logic       valid;
        logic       dump;
        logic [5:0] idx;
        logic [7:0] dest;
        logic [4:0] newm;
        logic [1:0] akind;
        logic [7:0] sender;
        logic       last;
        logic       found;
        logic       chg;
        logic       emit;
        logic [7:0] r_dest;
        logic [1:0] r_kind;
        logic [7:0] r_hop;
        logic [4:0] r_metric;
        logic       r_valid;
        logic [6:0] count;
    } dvrt_token_t;

endpackage

@@ sv/dvrt_in_if.sv @@
// Request channel: one command word per handshake.
interface dvrt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] destination;
    logic [4:0] advertised_metric;
    logic [7:0] sender_id;
    logic       advert_last;

    modport source (output valid, command, destination, advertised_metric, sender_id,
                    advert_last, input ready);
    modport sink (input valid, command, destination, advertised_metric, sender_id,
                  advert_last, output ready);
endinterface

@@ sv/dvrt_out_if.sv @@
// Result channel: one route word per handshake.
interface dvrt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_destination;
    logic [1:0] out_hop_kind;
    logic [7:0] out_next_hop;
    logic [4:0] out_metric;
    logic       out_valid;
    logic       out_last;
    logic       changed;
    logic       full_error;
    logic [6:0] entry_count;

    modport source (output valid, out_destination, out_hop_kind, out_next_hop, out_metric,
                    out_valid, out_last, changed, full_error, entry_count, input ready);
    modport sink (input valid, out_destination, out_hop_kind, out_next_hop, out_metric,
                  out_valid, out_last, changed, full_error, entry_count, output ready);
endinterface

@@ sv/distance_vector_route_table_top.sv @@
// Top level of the distance-vector route table: command issue, cell chain, result register.
//
// Usage: commands arrive on req, results leave on rsp, both valid/ready.
// The table is a row of TABLE_DEPTH cells, one route each. A command word
// becomes a token that walks the row one cell per cycle unless the row holds;
// the first cell whose destination matches updates in place, the first empty
// cell appends. A result passes through every cell's token register and then
// the result register. Commands 0 to 2 are taken one per cycle, several in
// flight at once, while no dump is issuing and rsp is not stalled. A dump
// issues one token per entry slot, so req.ready stays low after the dump word
// is taken until the last slot has been issued; it returns one word per valid
// entry in table order, or one empty word for an empty table, with out_last on the final word.
// The changed flag is tracked at the end of the row, in result order.
// Reset empties the table at once (no clearing pass) and sets changed.
// When rsp is stalled the whole row holds and req.ready drops.
module distance_vector_route_table_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    dvrt_in_if.sink           req,
    dvrt_out_if.source        rsp
);

    logic adv;
    logic dump_busy_reg, dump_busy_next;
    logic [5:0] dump_idx_reg, dump_idx_next;
    logic pending_reg, pending_next;
    logic ovalid_reg, ovalid_next;

    logic [7:0] o_dest_reg;
    logic [1:0] o_kind_reg;
    logic [7:0] o_hop_reg;
    logic [4:0] o_metric_reg;
    logic       o_valid_reg;
    logic       o_last_reg;
    logic       o_changed_reg, o_changed_next;
    logic       o_err_reg;
    logic [6:0] o_count_reg;

    dvrt_pkg::dvrt_token_t issue;
    dvrt_pkg::dvrt_token_t tok [TABLE_DEPTH+1];
    dvrt_pkg::dvrt_token_t tail;
    logic tail_emit;
    logic tail_last;

    assign adv       = !ovalid_reg || rsp.ready;
    assign req.ready = adv && !dump_busy_reg;

    always_comb
    begin
        issue        = '0;
        issue.sender = req.sender_id;
        issue.dest   = req.destination;
        issue.r_dest = req.destination;
        issue.last   = req.advert_last;
        if (dump_busy_reg)
        begin
            issue       = '0;
            issue.valid = 1'b1;
            issue.dump  = 1'b1;
            issue.idx   = dump_idx_reg;
        end
        else
        begin
            issue.valid = req.valid;
            unique case (dvrt_pkg::dvrt_cmd_t'(req.command))
                dvrt_pkg::CMD_ADVERT:
                begin
                    issue.akind = dvrt_pkg::KIND_VIA;
                    issue.newm  = (req.advertised_metric >= dvrt_pkg::METRIC_INF) ?
                                  dvrt_pkg::METRIC_INF : req.advertised_metric + 5'd1;
                end
                dvrt_pkg::CMD_REACHABLE:
                begin
                    issue.akind = dvrt_pkg::KIND_DIRECT;
                    issue.newm  = dvrt_pkg::METRIC_ONE;
                end
                dvrt_pkg::CMD_UNREACHABLE:
                begin
                    issue.akind = dvrt_pkg::KIND_NONE;
                    issue.newm  = dvrt_pkg::METRIC_INF;
                end
                dvrt_pkg::CMD_DUMP:
                begin
                    issue.dump = 1'b1;
                    issue.idx  = 6'd0;
                end
                default:
                begin
                    issue.dump = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        dump_busy_next = dump_busy_reg;
        dump_idx_next  = dump_idx_reg;
        if (adv)
        begin
            if (dump_busy_reg)
            begin
                if (dump_idx_reg == 6'(TABLE_DEPTH - 1))
                    dump_busy_next = 1'b0;
                else
                    dump_idx_next = dump_idx_reg + 6'd1;
            end
            else if (req.valid && req.command == dvrt_pkg::CMD_DUMP)
            begin
                dump_busy_next = 1'b1;
                dump_idx_next  = 6'd1;
            end
        end
    end

    assign tok[0] = issue;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        dvrt_cell #(
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tail      = tok[TABLE_DEPTH];
    assign tail_emit = tail.valid && (!tail.dump || tail.emit);
    assign tail_last = tail.last || (tail.dump && (7'(tail.idx) + 7'd1 == tail.count));

    always_comb
    begin
        pending_next   = pending_reg;
        o_changed_next = 1'b0;
        if (tail.valid)
        begin
            if (tail.dump)
                pending_next = 1'b0;
            else
            begin
                pending_next   = pending_reg || tail.chg;
                o_changed_next = pending_next;
            end
        end
        ovalid_next = tail_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dump_busy_reg <= 1'b0;
            dump_idx_reg  <= 6'd0;
            pending_reg   <= 1'b1;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            dump_busy_reg <= dump_busy_next;
            dump_idx_reg  <= dump_idx_next;
            if (adv)
            begin
                pending_reg <= pending_next;
                ovalid_reg  <= ovalid_next;
            end
        end
    end

    // hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (adv && tail_emit)
        begin
            o_dest_reg    <= tail.r_dest;
            o_kind_reg    <= tail.r_kind;
            o_hop_reg     <= tail.r_hop;
            o_metric_reg  <= tail.r_metric;
            o_valid_reg   <= tail.r_valid;
            o_last_reg    <= tail_last;
            o_changed_reg <= o_changed_next;
            o_err_reg     <= !tail.dump && !tail.found;
            o_count_reg   <= tail.count;
        end
    end

    assign rsp.valid           = ovalid_reg;
    assign rsp.out_destination = o_dest_reg;
    assign rsp.out_hop_kind    = o_kind_reg;
    assign rsp.out_next_hop    = o_hop_reg;
    assign rsp.out_metric      = o_metric_reg;
    assign rsp.out_valid       = o_valid_reg;
    assign rsp.out_last        = o_last_reg;
    assign rsp.changed         = o_changed_reg;
    assign rsp.full_error      = o_err_reg;
    assign rsp.entry_count     = o_count_reg;

endmodule

@@ sv/dvrt_cell.sv @@
// One table entry with its stage of the token chain.
module dvrt_cell #(
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  dvrt_pkg::dvrt_token_t tok_in,
    output dvrt_pkg::dvrt_token_t tok_out
);

    localparam logic IS_FIRST = (INDEX == 0);

    logic       v_reg, v_next;
    logic [7:0] dest_reg, dest_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] hop_reg, hop_next;
    logic [4:0] metric_reg, metric_next;
    dvrt_pkg::dvrt_token_t tok_reg, tok_next;

    always_comb
    begin
        tok_next    = tok_in;
        v_next      = v_reg;
        dest_next   = dest_reg;
        kind_next   = kind_reg;
        hop_next    = hop_reg;
        metric_next = metric_reg;
        if (tok_in.valid)
        begin
            if (tok_in.dump)
            begin
                if (tok_in.idx == 6'(INDEX))
                begin
                    tok_next.emit     = v_reg || IS_FIRST;
                    tok_next.r_valid  = v_reg;
                    tok_next.r_dest   = v_reg ? dest_reg : 8'd0;
                    tok_next.r_kind   = v_reg ? kind_reg : 2'd0;
                    tok_next.r_hop    = v_reg ? hop_reg : 8'd0;
                    tok_next.r_metric = v_reg ? metric_reg : 5'd0;
                    tok_next.last     = !v_reg;
                end
            end
            else if (!tok_in.found)
            begin
                if (!v_reg)
                begin
                    // append at first free entry
                    v_next         = 1'b1;
                    dest_next      = tok_in.dest;
                    kind_next      = tok_in.akind;
                    hop_next       = (tok_in.akind == dvrt_pkg::KIND_VIA) ? tok_in.sender
                                                                          : 8'd0;
                    metric_next    = tok_in.newm;
                    tok_next.found = 1'b1;
                    tok_next.chg   = 1'b1;
                end
                else if (dest_reg == tok_in.dest)
                begin
                    tok_next.found = 1'b1;
                    if (tok_in.akind == dvrt_pkg::KIND_VIA)
                    begin
                        if (kind_reg != dvrt_pkg::KIND_DIRECT)
                        begin
                            if (metric_reg > tok_in.newm)
                            begin
                                metric_next  = tok_in.newm;
                                kind_next    = dvrt_pkg::KIND_VIA;
                                hop_next     = tok_in.sender;
                                tok_next.chg = 1'b1;
                            end
                            else if (kind_reg == dvrt_pkg::KIND_VIA &&
                                     hop_reg == tok_in.sender &&
                                     metric_reg != tok_in.newm)
                            begin
                                metric_next  = tok_in.newm;
                                tok_next.chg = 1'b1;
                            end
                        end
                    end
                    else if (metric_reg != tok_in.newm)
                    begin
                        metric_next  = tok_in.newm;
                        tok_next.chg = 1'b1;
                    end
                end
                if (tok_next.found)
                begin
                    tok_next.r_valid  = 1'b1;
                    tok_next.r_dest   = dest_next;
                    tok_next.r_kind   = kind_next;
                    tok_next.r_hop    = hop_next;
                    tok_next.r_metric = metric_next;
                end
            end
            tok_next.count = tok_in.count + 7'(v_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            tok_reg <= '0;
        end
        else if (adv)
        begin
            v_reg   <= v_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dest_reg   <= dest_next;
            kind_reg   <= kind_next;
            hop_reg    <= hop_next;
            metric_reg <= metric_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the distance-vector route table top level.
module tb;

    localparam int TABLE_DEPTH = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int N_DIRECTED = 23;

    typedef struct packed {
        dvrt_pkg::dvrt_cmd_t cmd;
        logic [7:0] dest;
        logic [4:0] adv;
        logic [7:0] sender;
        logic       last;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0] dest;
        logic [1:0] kind;
        logic [7:0] hop;
        logic [4:0] metric;
        logic       present;
        logic       last;
        logic       changed;
        logic       full_err;
        logic [6:0] count;
    } route_word_t;

    typedef struct packed {
        cmd_word_t   w;
        logic        typed;
        route_word_t exp;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dvrt_in_if  req_if ();
    dvrt_out_if rsp_if ();

    distance_vector_route_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0] tbl_dest   [TABLE_DEPTH];
    logic [1:0] tbl_kind   [TABLE_DEPTH];
    logic [7:0] tbl_hop    [TABLE_DEPTH];
    logic [4:0] tbl_metric [TABLE_DEPTH];
    int         tbl_count = 0;
    logic       tbl_changed = 1'b1;

    route_word_t expected_routes [$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{'{dvrt_pkg::CMD_DUMP, 8'h00, 5'd0, 8'h00, 1'b0}, 1'b1,
          '{8'h00, dvrt_pkg::KIND_DIRECT, 8'h00, 5'd0,
            1'b0, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{'{dvrt_pkg::CMD_REACHABLE, 8'h00, 5'd0, 8'h00, 1'b1}, 1'b1,
          '{8'h00, dvrt_pkg::KIND_DIRECT, 8'h00, dvrt_pkg::METRIC_ONE,
            1'b1, 1'b1, 1'b1, 1'b0, 7'd1}},
        '{'{dvrt_pkg::CMD_UNREACHABLE, 8'hFF, 5'd0, 8'h00, 1'b0}, 1'b1,
          '{8'hFF, dvrt_pkg::KIND_NONE, 8'h00, dvrt_pkg::METRIC_INF,
            1'b1, 1'b0, 1'b1, 1'b0, 7'd2}},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hA5, 5'd0, 8'hFF, 1'b1}, 1'b1,
          '{8'hA5, dvrt_pkg::KIND_VIA, 8'hFF, 5'd1,
            1'b1, 1'b1, 1'b1, 1'b0, 7'd3}},
        '{'{dvrt_pkg::CMD_ADVERT, 8'h00, 5'd0, 8'h01, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hFF, 5'd31, 8'h5A, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_DUMP, 8'h00, 5'd0, 8'h00, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hFF, 5'd15, 8'h5A, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hFF, 5'd3, 8'h5A, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hFF, 5'd10, 8'h5A, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hFF, 5'd20, 8'h5A, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hFF, 5'd2, 8'h33, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hFF, 5'd2, 8'h44, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_DUMP, 8'h00, 5'd0, 8'h00, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hFF, 5'd2, 8'h33, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_REACHABLE, 8'hFF, 5'd0, 8'h00, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_REACHABLE, 8'hFF, 5'd0, 8'h00, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_UNREACHABLE, 8'h00, 5'd0, 8'h00, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'h00, 5'd0, 8'h07, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_UNREACHABLE, 8'hA5, 5'd0, 8'h00, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'hA5, 5'd31, 8'hFF, 1'b1}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_ADVERT, 8'h01, 5'd16, 8'h80, 1'b0}, 1'b0, '0},
        '{'{dvrt_pkg::CMD_DUMP, 8'h00, 5'd0, 8'h00, 1'b0}, 1'b0, '0}
    };

    task automatic route_update(input cmd_word_t w);
        int hit;
        logic [4:0] d;
        logic [1:0] k;
        logic [7:0] h;
        route_word_t r;
        hit = -1;
        r = '0;
        if (w.cmd == dvrt_pkg::CMD_DUMP)
        begin
            tbl_changed = 1'b0;
            if (tbl_count == 0)
            begin
                r.last = 1'b1;
                expected_routes.push_back(r);
            end
            for (int i = 0; i < tbl_count; i++)
            begin
                r.dest = tbl_dest[i];
                r.kind = tbl_kind[i];
                r.hop = tbl_hop[i];
                r.metric = tbl_metric[i];
                r.present = 1'b1;
                r.last = (i == tbl_count - 1);
                r.count = tbl_count[6:0];
                expected_routes.push_back(r);
            end
        end
        else
        begin
            case (w.cmd)
                dvrt_pkg::CMD_ADVERT:
                begin
                    d = (w.adv >= dvrt_pkg::METRIC_INF) ? dvrt_pkg::METRIC_INF
                                                        : w.adv + 5'd1;
                    k = dvrt_pkg::KIND_VIA;
                    h = w.sender;
                end
                dvrt_pkg::CMD_REACHABLE:
                begin
                    d = dvrt_pkg::METRIC_ONE;
                    k = dvrt_pkg::KIND_DIRECT;
                    h = 8'h00;
                end
                default:
                begin
                    d = dvrt_pkg::METRIC_INF;
                    k = dvrt_pkg::KIND_NONE;
                    h = 8'h00;
                end
            endcase
            for (int i = 0; i < tbl_count; i++)
                if (hit < 0 && tbl_dest[i] == w.dest)
                    hit = i;
            if (hit >= 0)
            begin
                if (w.cmd == dvrt_pkg::CMD_ADVERT)
                begin
                    if (tbl_kind[hit] != dvrt_pkg::KIND_DIRECT)
                    begin
                        if (tbl_metric[hit] > d)
                        begin
                            tbl_metric[hit] = d;
                            tbl_kind[hit] = dvrt_pkg::KIND_VIA;
                            tbl_hop[hit] = w.sender;
                            tbl_changed = 1'b1;
                        end
                        else if (tbl_kind[hit] == dvrt_pkg::KIND_VIA &&
                                 tbl_hop[hit] == w.sender &&
                                 tbl_metric[hit] != d)
                        begin
                            tbl_metric[hit] = d;
                            tbl_changed = 1'b1;
                        end
                    end
                end
                else if (tbl_metric[hit] != d)
                begin
                    tbl_metric[hit] = d;
                    tbl_changed = 1'b1;
                end
                r.dest = tbl_dest[hit];
                r.kind = tbl_kind[hit];
                r.hop = tbl_hop[hit];
                r.metric = tbl_metric[hit];
                r.present = 1'b1;
            end
            else if (tbl_count >= TABLE_DEPTH)
            begin
                r.dest = w.dest;
                r.full_err = 1'b1;
            end
            else
            begin
                tbl_dest[tbl_count] = w.dest;
                tbl_kind[tbl_count] = k;
                tbl_hop[tbl_count] = h;
                tbl_metric[tbl_count] = d;
                tbl_count++;
                tbl_changed = 1'b1;
                r.dest = w.dest;
                r.kind = k;
                r.hop = h;
                r.metric = d;
                r.present = 1'b1;
            end
            r.last = w.last;
            r.changed = tbl_changed;
            r.count = tbl_count[6:0];
            expected_routes.push_back(r);
        end
    endtask

    task automatic issue(input cmd_word_t w, input logic typed, input route_word_t typed_exp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.command <= w.cmd;
        req_if.destination <= w.dest;
        req_if.advertised_metric <= w.adv;
        req_if.sender_id <= w.sender;
        req_if.advert_last <= w.last;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        route_update(w);
        if (typed)
        begin
            void'(expected_routes.pop_back());
            expected_routes.push_back(typed_exp);
        end
    endtask

    function automatic logic [7:0] pick_dest();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(39));
    endfunction

    task automatic run_random(input int n_items);
        int sent;
        int pick;
        int len;
        logic [7:0] sender;
        cmd_word_t w;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            w = '0;
            w.last = 1'($urandom_range(1));
            if (pick < 10)
            begin
                w.cmd = dvrt_pkg::CMD_DUMP;
                w.dest = 8'($urandom_range(255));
                issue(w, 1'b0, '0);
                sent++;
            end
            else if (pick < 25)
            begin
                w.cmd = $urandom_range(1) ? dvrt_pkg::CMD_REACHABLE
                                          : dvrt_pkg::CMD_UNREACHABLE;
                w.dest = pick_dest();
                w.adv = 5'($urandom_range(31));
                w.sender = 8'($urandom_range(255));
                issue(w, 1'b0, '0);
                sent++;
            end
            else
            begin
                sender = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(5));
                len = $urandom_range(1, 5);
                for (int j = 0; j < len; j++)
                begin
                    w.cmd = dvrt_pkg::CMD_ADVERT;
                    w.dest = pick_dest();
                    w.adv = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31))
                                                     : 5'($urandom_range(16));
                    w.sender = sender;
                    w.last = (j == len - 1);
                    if ($urandom_range(9) == 0)
                        w.last = 1'($urandom_range(1));
                    issue(w, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        route_word_t got;
        route_word_t want;
        got = '{rsp_if.out_destination, rsp_if.out_hop_kind, rsp_if.out_next_hop,
                rsp_if.out_metric, rsp_if.out_valid, rsp_if.out_last, rsp_if.changed,
                rsp_if.full_error, rsp_if.entry_count};
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_routes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected route word: dest %0d kind %0d hop %0d metric %0d",
                             got.dest, got.kind, got.hop, got.metric);
            end
            else
            begin
                want = expected_routes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("route word mismatch at %0t", $realtime);
                        $display("  exp dest %0d kind %0d hop %0d metric %0d vld %0d last %0d",
                                 want.dest, want.kind, want.hop, want.metric, want.present,
                                 want.last);
                        $display("      changed %0d err %0d count %0d",
                                 want.changed, want.full_err, want.count);
                        $display("  got dest %0d kind %0d hop %0d metric %0d vld %0d last %0d",
                                 got.dest, got.kind, got.hop, got.metric, got.present,
                                 got.last);
                        $display("      changed %0d err %0d count %0d",
                                 got.changed, got.full_err, got.count);
                    end
                end
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL distance_vector_route_table_top");
            $finish;
        end
    end

    initial
    begin
        req_if.valid = 1'b0;
        req_if.command = dvrt_pkg::CMD_ADVERT;
        req_if.destination = 8'h00;
        req_if.advertised_metric = 5'd0;
        req_if.sender_id = 8'h00;
        req_if.advert_last = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 78;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct = 35;
                    stall_pct = 35;
                end
            endcase
            if (phase == 0)
                foreach (directed_rows[i])
                    issue(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].exp);
            run_random(ITEMS_PER_PHASE);
        end
        req_if.valid <= 1'b0;
        while (expected_routes.size() != 0)
            @(posedge clk);
        repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS distance_vector_route_table_top");
        else
            $display("FAIL distance_vector_route_table_top");
        $finish;
    end
endmodule
